@@ rtl/core/tsp_nearest_addition_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the nearest-addition tour block.
// Each macro is empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TSP_NEAREST_ADDITION_ASSERT_SVH
`define TSP_NEAREST_ADDITION_ASSERT_SVH
`ifndef SYNTH
`define TNA_CHECK(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("tna: invariant check failed");
`define TNA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tna: sequence check failed");
`else
`define TNA_CHECK(lbl, expr)
`define TNA_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/tna_pkg.sv @@
// ---------------------------------------------------------------------------
// tna_pkg
// Word types and fixed constants of the nearest-addition tour block.
// ---------------------------------------------------------------------------
package tna_pkg;

    localparam int COST_W = 30;
    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [5:0] NUM_CITIES_RESET = 6'd32;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_SOLVE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [4:0]  row_city;
        logic [4:0]  col_city;
        logic [23:0] dist_value;
        logic [4:0]  start_city;
    } t_in_word;

    typedef struct packed {
        logic [4:0]        tour_city;
        logic [5:0]        tour_position;
        logic              last;
        logic [COST_W-1:0] tour_cost;
    } t_out_word;

    typedef struct packed {
        logic [5:0] num_cities;
    } t_cfg_word;

endpackage

@@ rtl/core/tna_chan_if.sv @@
// ---------------------------------------------------------------------------
// tna_chan_if
// Valid/ready channel that moves one word of type T per handshake.
// ---------------------------------------------------------------------------
interface tna_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/tsp_nearest_addition.sv @@
// ---------------------------------------------------------------------------
// tsp_nearest_addition
// Builds a nearest-addition tour over a stored distance matrix. A load word
// writes one matrix entry. A solve word resets the visited set to the start
// city, then for each insertion scans every tour city against every city, one
// distance memory read per cycle, then prices the insertion, shifts the tour
// and places the city; after the last insertion it sums the tour cost and
// emits the tour one word per position. The distance memory has a single read
// port. The block takes one input word at a time; no clearing pass follows
// reset.
// ---------------------------------------------------------------------------
`include "tsp_nearest_addition_assert.svh"

module tsp_nearest_addition import tna_pkg::*; #(
    parameter int MAX_CITIES = 32,
    parameter int DIST_BITS  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tna_chan_if.sink    i_cfg,
    tna_chan_if.sink    i_in,
    tna_chan_if.source  o_out
);

    localparam int CW = $clog2(MAX_CITIES);
    localparam int NW = $clog2(MAX_CITIES + 1);
    localparam int IW = $clog2(MAX_CITIES + 2);
    localparam int AW = 2 * CW;
    localparam int XW = DIST_BITS + 1;
    localparam int SW = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;
    localparam logic [5:0] MAXC = 6'(MAX_CITIES);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_INIT   = 11'b00000000010,
        S_SCAN_T = 11'b00000000100,
        S_SCAN_D = 11'b00000001000,
        S_DRAIN  = 11'b00000010000,
        S_EVAL   = 11'b00000100000,
        S_SHIFT  = 11'b00001000000,
        S_PUT    = 11'b00010000000,
        S_COST   = 11'b00100000000,
        S_OUT_RD = 11'b01000000000,
        S_OUT_WR = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [5:0] r_num;
    logic [NW-1:0] w_n;
    logic [MAX_CITIES-1:0] r_vis;

    logic [DIST_BITS-1:0] r_dist_mem [0:(1 << AW)-1];
    logic [DIST_BITS-1:0] r_dq;
    logic w_d_re, w_d_we;
    logic [AW-1:0] w_d_ra, w_d_wa;
    logic [DIST_BITS-1:0] w_d_wd;

    logic [CW-1:0] r_tour_mem [0:MAX_CITIES];
    logic [CW-1:0] r_tq;
    logic w_t_re, w_t_we;
    logic [NW-1:0] w_t_ra, w_t_wa;
    logic [CW-1:0] w_t_wd;

    logic [CW-1:0] r_start;
    logic [NW-1:0] r_size, r_p, r_pos, r_ins, r_si, r_wa;
    logic [CW-1:0] r_k, r_city, r_ck;
    logic [NW-1:0] r_cp;
    logic r_cv, r_cvis, r_found, r_wpend;
    logic [DIST_BITS-1:0] r_best, r_x1, r_x2, r_x3, r_x4;
    logic [3:0] r_step;
    logic [CW-1:0] r_tpos, r_tia, r_tib;
    logic [NW-1:0] w_ia, w_ib;
    logic signed [XW-1:0] w_after, w_before;

    logic [IW-1:0] r_i;
    logic r_s1, r_s1first, r_s2;
    logic [CW-1:0] r_prev;
    logic [COST_W-1:0] r_cost;
    logic [SW-1:0] w_sum;

    logic r_ovalid;
    t_out_word r_odata;

    t_in_word w_in;
    logic w_load_ok, w_start_ok;

    assign w_in = i_in.data;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_odata;

    always_comb begin
        if (r_num < 6'd2) begin
            w_n = NW'(2);
        end else if (r_num > MAXC) begin
            w_n = NW'(MAX_CITIES);
        end else begin
            w_n = NW'(r_num);
        end
    end

    assign w_load_ok  = ({1'b0, w_in.row_city} < MAXC) && ({1'b0, w_in.col_city} < MAXC);
    assign w_start_ok = ({1'b0, w_in.start_city} < 6'(w_n));
    assign w_ia = r_pos + NW'(1);
    assign w_ib = (r_pos == '0) ? (r_size - NW'(1)) : (r_pos - NW'(1));
    assign w_after  = $signed({1'b0, r_x1}) - $signed({1'b0, r_x2});
    assign w_before = $signed({1'b0, r_x3}) - $signed({1'b0, r_x4});
    assign w_sum = SW'(r_cost) + SW'(r_dq);

    always_comb begin
        w_d_re = 1'b0;
        w_d_we = 1'b0;
        w_d_ra = '0;
        w_d_wa = {CW'(w_in.row_city), CW'(w_in.col_city)};
        w_d_wd = DIST_BITS'(w_in.dist_value);
        w_t_re = 1'b0;
        w_t_we = 1'b0;
        w_t_ra = '0;
        w_t_wa = '0;
        w_t_wd = r_start;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && w_in.mode == MODE_LOAD && w_load_ok) begin
                    w_d_we = 1'b1;
                end
                if (i_in.valid && w_in.mode == MODE_SOLVE && w_start_ok) begin
                    w_t_we = 1'b1;
                    w_t_wd = CW'(w_in.start_city);
                end
            end
            S_INIT: begin
                w_t_we = 1'b1;
                w_t_wa = NW'(1);
            end
            S_SCAN_T: begin
                w_t_re = 1'b1;
                w_t_ra = r_p;
            end
            S_SCAN_D: begin
                w_d_re = 1'b1;
                w_d_ra = {r_tq, r_k};
            end
            S_EVAL: begin
                case (r_step)
                    4'd0: begin
                        w_t_re = 1'b1;
                        w_t_ra = r_pos;
                    end
                    4'd1: begin
                        w_t_re = 1'b1;
                        w_t_ra = w_ia;
                    end
                    4'd2: begin
                        w_t_re = 1'b1;
                        w_t_ra = w_ib;
                    end
                    4'd3: begin
                        w_d_re = 1'b1;
                        w_d_ra = {r_tia, r_city};
                    end
                    4'd4: begin
                        w_d_re = 1'b1;
                        w_d_ra = {r_tpos, r_tia};
                    end
                    4'd5: begin
                        w_d_re = 1'b1;
                        w_d_ra = {r_tib, r_city};
                    end
                    4'd6: begin
                        w_d_re = 1'b1;
                        w_d_ra = {r_tpos, r_tib};
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                w_t_we = r_wpend;
                w_t_wa = r_wa;
                w_t_wd = r_tq;
                if (r_si > r_ins) begin
                    w_t_re = 1'b1;
                    w_t_ra = r_si - NW'(1);
                end
            end
            S_PUT: begin
                w_t_we = 1'b1;
                w_t_wa = r_ins;
                w_t_wd = r_city;
            end
            S_COST: begin
                if (r_i <= IW'(w_n)) begin
                    w_t_re = 1'b1;
                    w_t_ra = r_i[NW-1:0];
                end
                if (r_s1 && !r_s1first) begin
                    w_d_re = 1'b1;
                    w_d_ra = {r_prev, r_tq};
                end
            end
            S_OUT_RD: begin
                w_t_re = 1'b1;
                w_t_ra = r_i[NW-1:0];
            end
            S_DRAIN, S_OUT_WR: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_d_we) begin
            r_dist_mem[w_d_wa] <= w_d_wd;
        end
        if (w_d_re) begin
            r_dq <= r_dist_mem[w_d_ra];
        end
        if (w_t_we) begin
            r_tour_mem[w_t_wa] <= w_t_wd;
        end
        if (w_t_re) begin
            r_tq <= r_tour_mem[w_t_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_num    <= NUM_CITIES_RESET;
            r_vis    <= '0;
            r_ovalid <= 1'b0;
            r_cv     <= 1'b0;
            r_s1     <= 1'b0;
            r_s2     <= 1'b0;
            r_wpend  <= 1'b0;
            r_found  <= 1'b0;
            r_size   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_num <= i_cfg.data.num_cities;
            end
            if (o_out.ready && r_state != S_OUT_WR) begin
                r_ovalid <= 1'b0;
            end

            r_cv   <= (r_state == S_SCAN_D);
            r_ck   <= r_k;
            r_cp   <= r_p;
            r_cvis <= r_vis[r_k];
            if (r_cv && !r_cvis && (!r_found || r_dq < r_best)) begin
                r_found <= 1'b1;
                r_best  <= r_dq;
                r_pos   <= r_cp;
                r_city  <= r_ck;
            end

            r_s1      <= (r_state == S_COST) && (r_i <= IW'(w_n));
            r_s1first <= (r_i == '0);
            r_s2      <= r_s1 && !r_s1first;
            if (r_s1) begin
                r_prev <= r_tq;
            end
            if (r_s2) begin
                r_cost <= (w_sum > SW'(COST_MAX)) ? COST_MAX : w_sum[COST_W-1:0];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && w_in.mode == MODE_SOLVE && w_start_ok) begin
                        r_start <= CW'(w_in.start_city);
                        r_vis <= MAX_CITIES'(1) << w_in.start_city;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_size  <= NW'(1);
                    r_p     <= '0;
                    r_found <= 1'b0;
                    r_state <= S_SCAN_T;
                end
                S_SCAN_T: begin
                    r_k <= '0;
                    r_state <= S_SCAN_D;
                end
                S_SCAN_D: begin
                    r_k <= r_k + CW'(1);
                    if (NW'(r_k) == w_n - NW'(1)) begin
                        if (r_p == r_size - NW'(1)) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_p <= r_p + NW'(1);
                            r_state <= S_SCAN_T;
                        end
                    end
                end
                S_DRAIN: begin
                    r_step <= '0;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd1: r_tpos <= r_tq;
                        4'd2: r_tia <= r_tq;
                        4'd3: r_tib <= r_tq;
                        4'd4: r_x1 <= r_dq;
                        4'd5: r_x2 <= r_dq;
                        4'd6: r_x3 <= r_dq;
                        4'd7: r_x4 <= r_dq;
                        default: begin
                        end
                    endcase
                    if (r_size == NW'(1) || r_step == 4'd8) begin
                        if (r_size == NW'(1)) begin
                            r_ins <= NW'(1);
                        end else begin
                            r_ins <= (w_after < w_before) ? w_ia : (w_ib + NW'(1));
                        end
                        r_vis[r_city] <= 1'b1;
                        r_si <= r_size + NW'(1);
                        r_wpend <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_wpend <= (r_si > r_ins);
                    r_wa <= r_si;
                    if (r_si > r_ins) begin
                        r_si <= r_si - NW'(1);
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_size <= r_size + NW'(1);
                    if (r_size + NW'(1) < w_n) begin
                        r_p     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN_T;
                    end else begin
                        r_i     <= '0;
                        r_cost  <= '0;
                        r_state <= S_COST;
                    end
                end
                S_COST: begin
                    if (r_i <= IW'(w_n)) begin
                        r_i <= r_i + IW'(1);
                    end else if (!r_s1 && !r_s2) begin
                        r_i <= '0;
                        r_state <= S_OUT_RD;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_WR;
                end
                S_OUT_WR: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odata.tour_city <= 5'(r_tq);
                        r_odata.tour_position <= 6'(r_i);
                        r_odata.last <= (r_i == IW'(w_n));
                        r_odata.tour_cost <= (r_i == IW'(w_n)) ? r_cost : '0;
                        if (r_i == IW'(w_n)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + IW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TNA_CHECK(a_cost_on_last, !o_out.valid || o_out.data.last || o_out.data.tour_cost == '0)
    `TNA_CHECK(a_size_bound, r_state == S_IDLE || r_state == S_INIT || r_size <= w_n)
    `TNA_CHECK(a_pick_unvisited, !((r_state == S_SCAN_T || r_state == S_SCAN_D || r_state == S_DRAIN) && r_found) || !r_vis[r_city])
    `TNA_NEXT(a_put_grows, r_state == S_PUT, r_size == $past(r_size) + NW'(1))

endmodule
